/* rtl/stsf_pkg.sv */
// Shared types and constants for the subarray target sum finder.
// No dependencies; every other file of the block refers to this package.
package stsf_pkg;

    localparam int MAX_LEN = 1024;
    localparam int DATA_W  = 32;
    localparam int SUM_W   = 48;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int START_W = 11;
    localparam int END_W   = 10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SUB,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_FOUND,
        RES_TOOLONG
    } res_kind_t;

    typedef struct packed {
        logic      take;
        logic      rd_front;
        logic      sub_front;
        logic      clear;
        logic      set_done;
        logic      load_pend;
        res_kind_t pend_kind;
        logic      emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic full;
        logic gt;
        logic eq;
        logic last;
        logic in_last;
        logic out_free;
    } status_t;

endpackage

/* rtl/stsf_if.sv */
// Handshake channels of the subarray target sum finder: element input and result output.
// Depends on stsf_pkg for the field widths.
interface stsf_in_if;
    logic                        valid;
    logic                        ready;
    logic signed [stsf_pkg::DATA_W-1:0] element_value;
    logic                        is_last;

    modport source (output valid, output element_value, output is_last, input ready);
    modport sink (input valid, input element_value, input is_last, output ready);
endinterface

interface stsf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [stsf_pkg::START_W-1:0] start_index;
    logic [stsf_pkg::END_W-1:0]   end_index;
    logic                         too_long;

    modport source (output valid, output found, output start_index, output end_index,
                    output too_long, input ready);
    modport sink (input valid, input found, input start_index, input end_index,
                  input too_long, output ready);
endinterface

/* rtl/stsf_ctrl.sv */
// Sequencer of the subarray target sum finder: steps each item through take,
// window shrink and result emission. Depends on stsf_pkg.
module stsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  stsf_pkg::status_t st,
    output stsf_pkg::cmd_t    cmd
);

    stsf_pkg::state_t state_reg;
    stsf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stsf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.pend_kind = stsf_pkg::RES_NONE;
        in_ready      = 1'b0;
        case (state_reg)
            stsf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (st.done)
                    begin
                        // The rest of a finished array is dropped until its last item.
                        cmd.clear = st.in_last;
                    end
                    else if (st.full)
                    begin
                        cmd.load_pend = 1'b1;
                        cmd.pend_kind = stsf_pkg::RES_TOOLONG;
                        cmd.set_done  = 1'b1;
                        cmd.clear     = st.in_last;
                        state_next    = stsf_pkg::S_EMIT;
                    end
                    else
                    begin
                        cmd.take   = 1'b1;
                        state_next = stsf_pkg::S_CHECK;
                    end
                end
            end
            stsf_pkg::S_CHECK:
            begin
                if (st.gt)
                begin
                    cmd.rd_front = 1'b1;
                    state_next   = stsf_pkg::S_SUB;
                end
                else
                begin
                    cmd.clear = st.last;
                    if (st.eq)
                    begin
                        cmd.load_pend = 1'b1;
                        cmd.pend_kind = stsf_pkg::RES_FOUND;
                        cmd.set_done  = 1'b1;
                        state_next    = stsf_pkg::S_EMIT;
                    end
                    else if (st.last)
                    begin
                        cmd.load_pend = 1'b1;
                        cmd.pend_kind = stsf_pkg::RES_NONE;
                        state_next    = stsf_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = stsf_pkg::S_IDLE;
                    end
                end
            end
            stsf_pkg::S_SUB:
            begin
                cmd.sub_front = 1'b1;
                state_next    = stsf_pkg::S_CHECK;
            end
            stsf_pkg::S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stsf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stsf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/stsf_dp.sv */
// Datapath of the subarray target sum finder: element store, window sum and
// indices, target register and output register. Depends on stsf_pkg.
module stsf_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stsf_pkg::DATA_W-1:0]        cfg_wdata,
    input  logic signed [stsf_pkg::DATA_W-1:0] in_value,
    input  logic                               in_last,
    input  stsf_pkg::cmd_t                     cmd,
    output stsf_pkg::status_t                  st,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_found,
    output logic [stsf_pkg::START_W-1:0]       out_start,
    output logic [stsf_pkg::END_W-1:0]         out_end,
    output logic                               out_too_long
);

    localparam int EXT_W = stsf_pkg::SUM_W - stsf_pkg::DATA_W;

    logic signed [stsf_pkg::DATA_W-1:0] mem [stsf_pkg::MAX_LEN];
    logic signed [stsf_pkg::DATA_W-1:0] rdata_reg;

    logic signed [stsf_pkg::DATA_W-1:0] target_reg;
    logic signed [stsf_pkg::SUM_W-1:0]  sum_reg;
    logic signed [stsf_pkg::SUM_W-1:0]  sum_next;
    logic [stsf_pkg::CNT_W-1:0]         start_reg;
    logic [stsf_pkg::CNT_W-1:0]         start_next;
    logic [stsf_pkg::CNT_W-1:0]         count_reg;
    logic [stsf_pkg::CNT_W-1:0]         count_next;
    logic [stsf_pkg::ADDR_W-1:0]        idx_reg;
    logic                               last_reg;
    logic                               done_reg;
    logic                               done_next;

    logic                               pend_found_reg;
    logic [stsf_pkg::START_W-1:0]       pend_start_reg;
    logic [stsf_pkg::END_W-1:0]         pend_end_reg;
    logic                               pend_too_long_reg;

    logic                               out_valid_reg;
    logic                               out_found_reg;
    logic [stsf_pkg::START_W-1:0]       out_start_reg;
    logic [stsf_pkg::END_W-1:0]         out_end_reg;
    logic                               out_too_long_reg;

    logic signed [stsf_pkg::SUM_W-1:0]  target_ext;

    assign target_ext = {{EXT_W{target_reg[stsf_pkg::DATA_W-1]}}, target_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mem[count_reg[stsf_pkg::ADDR_W-1:0]] <= in_value;
        end
        if (cmd.rd_front)
        begin
            rdata_reg <= mem[start_reg[stsf_pkg::ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        start_next = start_reg;
        count_next = count_reg;
        done_next  = done_reg;
        if (cmd.take)
        begin
            sum_next   = sum_reg + {{EXT_W{in_value[stsf_pkg::DATA_W-1]}}, in_value};
            count_next = count_reg + 1'b1;
        end
        if (cmd.sub_front)
        begin
            sum_next   = sum_reg - {{EXT_W{rdata_reg[stsf_pkg::DATA_W-1]}}, rdata_reg};
            start_next = start_reg + 1'b1;
        end
        if (cmd.set_done)
        begin
            done_next = 1'b1;
        end
        // The end of an array wins over everything else and starts a fresh one.
        if (cmd.clear)
        begin
            sum_next   = '0;
            start_next = '0;
            count_next = '0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            sum_reg       <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
            sum_reg   <= sum_next;
            start_reg <= start_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            idx_reg  <= count_reg[stsf_pkg::ADDR_W-1:0];
            last_reg <= in_last;
        end
        if (cmd.load_pend)
        begin
            case (cmd.pend_kind)
                stsf_pkg::RES_FOUND:
                begin
                    pend_found_reg    <= 1'b1;
                    pend_start_reg    <= start_reg[stsf_pkg::START_W-1:0];
                    pend_end_reg      <= idx_reg[stsf_pkg::END_W-1:0];
                    pend_too_long_reg <= 1'b0;
                end
                stsf_pkg::RES_TOOLONG:
                begin
                    pend_found_reg    <= 1'b0;
                    pend_start_reg    <= '0;
                    pend_end_reg      <= '0;
                    pend_too_long_reg <= 1'b1;
                end
                default:
                begin
                    pend_found_reg    <= 1'b0;
                    pend_start_reg    <= '0;
                    pend_end_reg      <= '0;
                    pend_too_long_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.emit)
        begin
            out_found_reg    <= pend_found_reg;
            out_start_reg    <= pend_start_reg;
            out_end_reg      <= pend_end_reg;
            out_too_long_reg <= pend_too_long_reg;
        end
    end

    always_comb
    begin
        st.done     = done_reg;
        st.full     = (count_reg >= stsf_pkg::CNT_W'(stsf_pkg::MAX_LEN));
        // The front may pass the newest element, which leaves an empty window.
        st.gt       = (sum_reg > target_ext) && (start_reg <= {1'b0, idx_reg});
        st.eq       = (sum_reg == target_ext);
        st.last     = last_reg;
        st.in_last  = in_last;
        st.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = out_found_reg;
    assign out_start    = out_start_reg;
    assign out_end      = out_end_reg;
    assign out_too_long = out_too_long_reg;

endmodule

/* rtl/subarray_target_sum_finder_unit.sv */
// Top level of the subarray target sum finder: the sequencer and datapath joined
// to the element and result channels. Depends on stsf_pkg, stsf_if, stsf_ctrl, stsf_dp.
//
// Elements of one array arrive in order on in_ch, the last one flagged by is_last;
// the user must write the target through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce it. Each element is first accepted,
// then the window sum is compared against the target and, when it yields a
// result, the result moves into the output register once that register is free.
// Every element dropped from the front of the window adds a read of the element
// store and then a subtraction; each element leaves at most once. Items after a
// match or a too-long report are accepted and dropped at one item per cycle. A
// finished result waits in the output register while the next item is accepted;
// a newer result holds the input until that register has been taken.
module subarray_target_sum_finder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [stsf_pkg::DATA_W-1:0]   cfg_wdata,
    stsf_in_if.sink                       in_ch,
    stsf_out_if.source                    out_ch
);

    stsf_pkg::cmd_t    cmd;
    stsf_pkg::status_t st;

    stsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    stsf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_value     (in_ch.element_value),
        .in_last      (in_ch.is_last),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_found    (out_ch.found),
        .out_start    (out_ch.start_index),
        .out_end      (out_ch.end_index),
        .out_too_long (out_ch.too_long)
    );

endmodule
